### rtl/pwcc_pkg.sv
`timescale 1ns / 1ps

package pwcc_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_IDX_W     = 3;
    localparam int CH_CNT_W     = 4;
    localparam int WIDTH_W      = 3;
    localparam int CFG_DATA_W   = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int SAMPLE_W     = 32;

    localparam logic [SAMPLE_W-1:0] POS_FULL_SCALE = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] INT32_ONE      = 32'd1;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 3'd3;

    typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    // clamped configuration as seen by front and back
    typedef struct packed {
        logic [WIDTH_W-1:0]  ibytes;
        logic [WIDTH_W-1:0]  obytes;
        logic [CH_CNT_W-1:0] icount;
        logic [CH_CNT_W-1:0] ocount;
    } cfg_t;

    typedef struct packed {
        frame_t words;
        logic   eob;
    } job_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w < WIDTH_W'(1))
            r = WIDTH_W'(1);
        else if (w > WIDTH_W'(4))
            r = WIDTH_W'(4);
        return r;
    endfunction

    function automatic logic [CH_CNT_W-1:0] clamp_count(logic [CH_CNT_W-1:0] c);
        logic [CH_CNT_W-1:0] r;
        r = c;
        if (c < CH_CNT_W'(1))
            r = CH_CNT_W'(1);
        else if (c > CH_CNT_W'(MAX_CHANNELS))
            r = CH_CNT_W'(MAX_CHANNELS);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] left_justify(logic [SAMPLE_W-1:0] raw,
                                                         logic [WIDTH_W-1:0] nb);
        logic [SAMPLE_W-1:0] r;
        case (nb)
            3'd1:    r = {raw[7:0], 24'd0};
            3'd2:    r = {raw[15:0], 16'd0};
            3'd3:    r = {raw[23:0], 8'd0};
            default: r = raw;
        endcase
        return r;
    endfunction

    // when narrowing, round half an output lsb up (saturating); then keep the top bytes
    function automatic logic [SAMPLE_W-1:0] convert_word(logic [SAMPLE_W-1:0] w,
                                                         logic [WIDTH_W-1:0] ib,
                                                         logic [WIDTH_W-1:0] ob);
        logic [4:0]          sh;
        logic [SAMPLE_W-1:0] term;
        logic [SAMPLE_W-1:0] cap;
        logic [SAMPLE_W-1:0] v;
        case (ob)
            3'd1:    sh = 5'd24;
            3'd2:    sh = 5'd16;
            3'd3:    sh = 5'd8;
            default: sh = 5'd0;
        endcase
        term = INT32_ONE << (5'(sh - 5'd1));
        cap  = POS_FULL_SCALE - term;
        v    = w;
        if (ob < ib)
        begin
            if ($signed(v) > $signed(cap))
                v = cap;
            v = v + term;
        end
        return v >> sh;
    endfunction

endpackage

### rtl/pwcc_front.sv
`timescale 1ns / 1ps

module pwcc_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pwcc_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               sample_raw,
    input  logic                      end_of_buffer,
    output logic                      push,
    output pwcc_pkg::job_t            push_job,
    input  logic                      queue_full
);

    logic [pwcc_pkg::CH_IDX_W-1:0] capture_idx_reg;
    logic [pwcc_pkg::CH_IDX_W-1:0] capture_idx_next;
    pwcc_pkg::frame_t              store_reg;
    logic [pwcc_pkg::SAMPLE_W-1:0] justified;
    logic [pwcc_pkg::CH_CNT_W-1:0] pos_plus;
    logic                          frame_end;
    logic                          accept;

    assign pos_plus  = pwcc_pkg::CH_CNT_W'(capture_idx_reg) + pwcc_pkg::CH_CNT_W'(1);
    assign frame_end = !(pos_plus < cfg.icount);
    assign in_ready  = !(frame_end && queue_full);
    assign accept    = in_valid && in_ready;
    assign justified = pwcc_pkg::left_justify(sample_raw, cfg.ibytes);
    assign push      = accept && frame_end;

    // snapshot of the finished frame with the arriving word in place
    always_comb
    begin
        for (int i = 0; i < pwcc_pkg::MAX_CHANNELS; i++)
        begin
            if (pwcc_pkg::CH_IDX_W'(i) == capture_idx_reg)
                push_job.words[i] = justified;
            else
                push_job.words[i] = store_reg[i];
        end
        push_job.eob = end_of_buffer;
    end

    always_comb
    begin
        capture_idx_next = capture_idx_reg;
        if (accept)
        begin
            if (frame_end || end_of_buffer)
                capture_idx_next = '0;
            else
                capture_idx_next = pos_plus[pwcc_pkg::CH_IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capture_idx_reg <= '0;
        else
            capture_idx_reg <= capture_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            store_reg[capture_idx_reg] <= justified;
    end

endmodule

### rtl/pwcc_queue.sv
`timescale 1ns / 1ps

module pwcc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwcc_pkg::job_t push_job,
    input  logic           pop,
    output pwcc_pkg::job_t head,
    output logic           full,
    output logic           empty
);

    pwcc_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/pwcc_back.sv
`timescale 1ns / 1ps

module pwcc_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pwcc_pkg::cfg_t                 cfg,
    input  pwcc_pkg::job_t                 head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    out_sample,
    output logic [pwcc_pkg::CH_IDX_W-1:0]  out_channel,
    output logic                           last_in_frame,
    output logic                           buffer_done
);

    logic [pwcc_pkg::CH_IDX_W-1:0] k_reg;
    logic [pwcc_pkg::CH_IDX_W-1:0] src;
    logic [pwcc_pkg::CH_IDX_W-1:0] last_src;
    logic [pwcc_pkg::CH_CNT_W-1:0] k_plus;
    logic [pwcc_pkg::SAMPLE_W-1:0] converted;
    logic                          last;
    logic                          fire;
    logic                          out_valid_reg;
    logic [pwcc_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic [pwcc_pkg::CH_IDX_W-1:0] out_channel_reg;
    logic                          last_reg;
    logic                          done_reg;

    assign last_src  = pwcc_pkg::CH_IDX_W'(cfg.icount - pwcc_pkg::CH_CNT_W'(1));
    assign src       = (k_reg < last_src) ? k_reg : last_src;
    assign k_plus    = pwcc_pkg::CH_CNT_W'(k_reg) + pwcc_pkg::CH_CNT_W'(1);
    assign last      = (k_plus == cfg.ocount);
    assign fire      = !empty && (!out_valid_reg || out_ready);
    assign pop       = fire && last;
    assign converted = pwcc_pkg::convert_word(head.words[src], cfg.ibytes, cfg.obytes);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                k_reg         <= last ? '0 : k_plus[pwcc_pkg::CH_IDX_W-1:0];
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_sample_reg  <= converted;
            out_channel_reg <= k_reg;
            last_reg        <= last;
            done_reg        <= last && head.eob;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign out_channel   = out_channel_reg;
    assign last_in_frame = last_reg;
    assign buffer_done   = done_reg;

endmodule

### rtl/pcm_width_channel_converter_core.sv
`timescale 1ns / 1ps
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------------
// in       | in_valid / in_ready       | sample_raw, end_of_buffer
// out      | out_valid / out_ready     | out_sample, out_channel, last_in_frame,
//          |                           | buffer_done
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// the front takes one input word per cycle and hands each finished frame to a
// two-entry queue; the back drains one frame at one output word per cycle unless
// the output stalls, so a frame of n output channels yields n output words.
// the front stalls only on the word that closes a frame while both queue entries
// are taken; a stalled output word holds the back while the queue takes frames.
// reset is asynchronous and active low; it empties the queue and the output stage.

module pcm_width_channel_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_raw,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_sample,
    output logic [2:0]  out_channel,
    output logic        last_in_frame,
    output logic        buffer_done
);

    logic [pwcc_pkg::WIDTH_W-1:0]  in_width_reg;
    logic [pwcc_pkg::WIDTH_W-1:0]  out_width_reg;
    logic [pwcc_pkg::CH_CNT_W-1:0] in_count_reg;
    logic [pwcc_pkg::CH_CNT_W-1:0] out_count_reg;
    pwcc_pkg::cfg_t                cfg;
    pwcc_pkg::job_t                push_job;
    pwcc_pkg::job_t                head;
    logic                          push;
    logic                          pop;
    logic                          full;
    logic                          empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= pwcc_pkg::WIDTH_W'(2);
            out_width_reg <= pwcc_pkg::WIDTH_W'(2);
            in_count_reg  <= pwcc_pkg::CH_CNT_W'(2);
            out_count_reg <= pwcc_pkg::CH_CNT_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwcc_pkg::REG_IN_WIDTH:  in_width_reg  <= cfg_data[pwcc_pkg::WIDTH_W-1:0];
                pwcc_pkg::REG_OUT_WIDTH: out_width_reg <= cfg_data[pwcc_pkg::WIDTH_W-1:0];
                pwcc_pkg::REG_IN_COUNT:  in_count_reg  <= cfg_data;
                pwcc_pkg::REG_OUT_COUNT: out_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.ibytes = pwcc_pkg::clamp_width(in_width_reg);
    assign cfg.obytes = pwcc_pkg::clamp_width(out_width_reg);
    assign cfg.icount = pwcc_pkg::clamp_count(in_count_reg);
    assign cfg.ocount = pwcc_pkg::clamp_count(out_count_reg);

    pwcc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_raw    (sample_raw),
        .end_of_buffer (end_of_buffer),
        .push          (push),
        .push_job      (push_job),
        .queue_full    (full)
    );

    pwcc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    pwcc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_sample    (out_sample),
        .out_channel   (out_channel),
        .last_in_frame (last_in_frame),
        .buffer_done   (buffer_done)
    );

endmodule

### rtl/pwcc_checker.sv
`timescale 1ns / 1ps

module pwcc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_sample,
    input logic [2:0]  out_channel,
    input logic        last_in_frame,
    input logic        buffer_done
);

    // output stage is empty right after reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output word valid right after reset");

    // a run can only end on the closing word of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buffer_done |-> last_in_frame)
        else $error("buffer_done without last_in_frame");

    // the highest channel index always closes its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_channel == 3'd7 |-> last_in_frame)
        else $error("channel 7 not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample)
            && $stable(out_channel) && $stable(last_in_frame) && $stable(buffer_done))
        else $error("stalled output word changed");

endmodule

bind pcm_width_channel_converter_core pwcc_checker u_pwcc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_channel   (out_channel),
    .last_in_frame (last_in_frame),
    .buffer_done   (buffer_done)
);
